@@ hdl/roel_pkg.sv @@
// Shared constants for the ring of entries with byte offset lookup.
package roel_pkg;

    localparam int RING_DEPTH_DEF = 16;

    localparam int HANDLE_W   = 32;
    localparam int LENGTH_W   = 16;
    localparam int POS_W      = 20;
    localparam int SLOT_OUT_W = 4;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 2;

    localparam int ENTRY_W = HANDLE_W + LENGTH_W;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FIND = 1'b1;

endpackage

@@ hdl/roel_ram.sv @@
// Generic single write port, single read port RAM with registered read data.
module roel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/ring_of_entries_offset_lookup_top.sv @@
// Ring of entries with byte offset lookup: ring pointers, find walker, output register.
// Add: the entry is written at acceptance and its result word is valid the next cycle.
// Find: one stored entry is checked per cycle through the entry RAM read port, walking
//   from the oldest; a hit (remaining position below the entry length) or a miss over all
//   stored entries sets the result word, which is loaded once the output register is free.
// One item is in work at a time; the next is taken only in idle and with the output register free.
// Reset (aresetn low, synchronous) empties the ring; entry RAM contents are not cleared.
module ring_of_entries_offset_lookup_top #(
    parameter int RING_DEPTH = roel_pkg::RING_DEPTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // entry_handle[31:0], entry_length[47:32], byte_position[67:48], zero pad
    input  logic [roel_pkg::S_TDATA_W-1:0] s_tdata,
    // action[0]
    input  logic [roel_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // slot[3:0], hit_handle[35:4], offset_in_entry[51:36], zero pad
    output logic [roel_pkg::M_TDATA_W-1:0] m_tdata,
    // hit[0], overwrote_oldest[1]
    output logic [roel_pkg::M_TUSER_W-1:0] m_tuser
);

    localparam int SLOT_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FIND = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [SLOT_W-1:0]            write_slot_reg, write_slot_next;
    logic [SLOT_W-1:0]            read_slot_reg, read_slot_next;
    logic                         ring_full_reg, ring_full_next;
    logic                         rvalid_reg, rvalid_next;
    logic                         m_valid_reg, m_valid_next;

    logic [roel_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [SLOT_W-1:0]            chk_slot_reg, chk_slot_next;
    logic [SLOT_W-1:0]            iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]             chk_left_reg, chk_left_next;
    logic [CNT_W-1:0]             iss_left_reg, iss_left_next;

    logic                         f_hit_reg, f_hit_next;
    logic [SLOT_W-1:0]            f_slot_reg, f_slot_next;
    logic [roel_pkg::HANDLE_W-1:0] f_handle_reg, f_handle_next;
    logic [roel_pkg::LENGTH_W-1:0] f_off_reg, f_off_next;

    logic                         out_hit_reg, out_hit_next;
    logic [roel_pkg::SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [roel_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic [roel_pkg::LENGTH_W-1:0] out_off_reg, out_off_next;
    logic                         out_ovw_reg, out_ovw_next;

    logic                          in_acc;
    logic                          out_free;
    logic                          is_add;
    logic                          issue;
    logic [roel_pkg::HANDLE_W-1:0] in_handle;
    logic [roel_pkg::LENGTH_W-1:0] in_length;
    logic [roel_pkg::POS_W-1:0]    in_pos;
    logic [roel_pkg::ENTRY_W-1:0]  rd_data;
    logic [roel_pkg::HANDLE_W-1:0] rd_handle;
    logic [roel_pkg::LENGTH_W-1:0] rd_length;
    logic [SLOT_W-1:0]             add_write_slot;
    logic [SLOT_W-1:0]             add_read_slot;
    logic [CNT_W-1:0]              stored;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
    endfunction

    assign in_handle = s_tdata[31:0];
    assign in_length = s_tdata[47:32];
    assign in_pos    = s_tdata[67:48];
    assign is_add    = (s_tuser[0] == roel_pkg::ACT_ADD);

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign in_acc   = s_tvalid && s_tready;
    assign issue    = (state_reg == ST_FIND) && (iss_left_reg != '0);

    assign rd_handle = rd_data[roel_pkg::HANDLE_W-1:0];
    assign rd_length = rd_data[roel_pkg::ENTRY_W-1:roel_pkg::HANDLE_W];

    assign add_write_slot = slot_inc(write_slot_reg);
    assign add_read_slot  = ring_full_reg ? slot_inc(read_slot_reg) : read_slot_reg;

    assign stored = ring_full_reg ? CNT_W'(RING_DEPTH)
                  : (write_slot_reg >= read_slot_reg)
                    ? CNT_W'(write_slot_reg) - CNT_W'(read_slot_reg)
                    : CNT_W'(write_slot_reg) + CNT_W'(RING_DEPTH) - CNT_W'(read_slot_reg);

    roel_ram #(
        .WIDTH (roel_pkg::ENTRY_W),
        .DEPTH (RING_DEPTH)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (in_acc && is_add),
        .wr_addr (write_slot_reg),
        .wr_data ({in_length, in_handle}),
        .rd_en   (issue),
        .rd_addr (iss_addr_reg),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next      = state_reg;
        write_slot_next = write_slot_reg;
        read_slot_next  = read_slot_reg;
        ring_full_next  = ring_full_reg;
        rvalid_next     = issue;
        m_valid_next    = m_valid_reg && !m_tready;
        pos_next        = pos_reg;
        chk_slot_next   = chk_slot_reg;
        iss_addr_next   = iss_addr_reg;
        chk_left_next   = chk_left_reg;
        iss_left_next   = iss_left_reg;
        f_hit_next      = f_hit_reg;
        f_slot_next     = f_slot_reg;
        f_handle_next   = f_handle_reg;
        f_off_next      = f_off_reg;
        out_hit_next    = out_hit_reg;
        out_slot_next   = out_slot_reg;
        out_handle_next = out_handle_reg;
        out_off_next    = out_off_reg;
        out_ovw_next    = out_ovw_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    if (is_add) begin
                        write_slot_next = add_write_slot;
                        read_slot_next  = add_read_slot;
                        ring_full_next  = ring_full_reg || (add_write_slot == add_read_slot);
                        out_hit_next    = 1'b0;
                        out_slot_next   = roel_pkg::SLOT_OUT_W'(write_slot_reg);
                        out_handle_next = '0;
                        out_off_next    = '0;
                        out_ovw_next    = ring_full_reg;
                        m_valid_next    = 1'b1;
                    end else begin
                        pos_next      = in_pos;
                        chk_slot_next = read_slot_reg;
                        iss_addr_next = read_slot_reg;
                        chk_left_next = stored;
                        iss_left_next = stored;
                        state_next    = ST_FIND;
                    end
                end
            end
            ST_FIND: begin
                if (issue) begin
                    iss_addr_next = slot_inc(iss_addr_reg);
                    iss_left_next = iss_left_reg - 1'b1;
                end
                if (chk_left_reg == '0) begin
                    f_hit_next    = 1'b0;
                    f_slot_next   = '0;
                    f_handle_next = '0;
                    f_off_next    = '0;
                    state_next    = ST_FIN;
                end else if (rvalid_reg) begin
                    if (pos_reg < roel_pkg::POS_W'(rd_length)) begin
                        f_hit_next    = 1'b1;
                        f_slot_next   = chk_slot_reg;
                        f_handle_next = rd_handle;
                        f_off_next    = pos_reg[roel_pkg::LENGTH_W-1:0];
                        state_next    = ST_FIN;
                    end else begin
                        pos_next      = pos_reg - roel_pkg::POS_W'(rd_length);
                        chk_slot_next = slot_inc(chk_slot_reg);
                        chk_left_next = chk_left_reg - 1'b1;
                    end
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    out_hit_next    = f_hit_reg;
                    out_slot_next   = roel_pkg::SLOT_OUT_W'(f_slot_reg);
                    out_handle_next = f_handle_reg;
                    out_off_next    = f_off_reg;
                    out_ovw_next    = 1'b0;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            write_slot_reg <= '0;
            read_slot_reg  <= '0;
            ring_full_reg  <= 1'b0;
            rvalid_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            read_slot_reg  <= read_slot_next;
            ring_full_reg  <= ring_full_next;
            rvalid_reg     <= rvalid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg        <= pos_next;
        chk_slot_reg   <= chk_slot_next;
        iss_addr_reg   <= iss_addr_next;
        chk_left_reg   <= chk_left_next;
        iss_left_reg   <= iss_left_next;
        f_hit_reg      <= f_hit_next;
        f_slot_reg     <= f_slot_next;
        f_handle_reg   <= f_handle_next;
        f_off_reg      <= f_off_next;
        out_hit_reg    <= out_hit_next;
        out_slot_reg   <= out_slot_next;
        out_handle_reg <= out_handle_next;
        out_off_reg    <= out_off_next;
        out_ovw_reg    <= out_ovw_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0000, out_off_reg, out_handle_reg, out_slot_reg};
    assign m_tuser  = {out_ovw_reg, out_hit_reg};

`ifndef SYNTHESIS
    a_full_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_full_reg |=> ring_full_reg)
        else $error("ring full flag cleared without reset");

    a_full_slots_meet: assert property (@(posedge aclk) disable iff (!aresetn)
        ring_full_reg |-> (write_slot_reg == read_slot_reg))
        else $error("ring full while write and read slots differ");

    a_add_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && is_add) |=> (m_tvalid && !m_tuser[0]))
        else $error("add accepted without a result word in the next cycle");

    a_issue_ahead: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIND) |-> (iss_left_reg <= chk_left_reg))
        else $error("entry reads fell behind entry checks");
`endif

endmodule
